>>> hdl/fswm_pkg.sv
// Shared types, codes and helpers for the fuzzy subsequence window match unit.
// Used by fswm_cell and by the top level; depends on nothing else.
package fswm_pkg;

   // Default sizes handed to the top-level parameters.
   localparam int DEFAULT_MAX_QUERY     = 16;
   localparam int DEFAULT_POSITION_BITS = 16;

   // Fixed field widths of the configuration port and the result channel.
   localparam int QUERY_LEN_BITS  = 5;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 64;
   localparam int CHAR_BITS       = 8;
   localparam int MATCH_BITS      = 17;
   localparam int STR_LEN_BITS    = 16;
   localparam int CHARS_PER_WORD  = 8;

   // Width that holds any window or position value before saturation.
   localparam int WIDE_BITS = 34;
   localparam logic [WIDE_BITS-1:0] MATCH_MAX   = WIDE_BITS'((64'd1 << MATCH_BITS) - 64'd1);
   localparam logic [WIDE_BITS-1:0] STR_LEN_MAX = WIDE_BITS'((64'd1 << STR_LEN_BITS) - 64'd1);

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_QUERY_LEN  = 2'd0,
      CSR_CHARS_LOW  = 2'd1,
      CSR_CHARS_HIGH = 2'd2
   } csr_index_type;

   // Score kinds reported with each result.
   typedef enum logic [1:0] {
      SCORE_ZERO  = 2'd0,
      SCORE_FULL  = 2'd1,
      SCORE_RATIO = 2'd2
   } score_kind_type;

   // Per-cycle control that the top level hands to every cell.
   typedef struct packed {
      logic take;    // a counted character is transferred this cycle
      logic clear;   // an end item is transferred this cycle
      logic in_use;  // this cell lies inside the active query
      logic last;    // this cell holds the final query character
   } cell_ctrl_type;

   // ASCII case folding: upper-case letters map to lower case.
   function automatic logic [CHAR_BITS-1:0] fold_case(input logic [CHAR_BITS-1:0] c);
      logic [CHAR_BITS-1:0] r;
      r = c;
      if ((c >= 8'h41) && (c <= 8'h5A)) begin
         r = c + 8'h20;
      end
      return r;
   endfunction

endpackage

>>> hdl/fuzzy_subsequence_window_match_unit.sv
// Top level of the fuzzy subsequence window match unit: registers, cell chain, result.
// Depends on fswm_pkg and fswm_cell.
//
// The unit takes one string character per clock cycle and ends each string with
// an end item; one result follows each end item, registered, in the next cycle.
// Every query prefix has its own cell, and the whole chain updates in the cycle
// a character is transferred, so the sustained rate is one item per cycle. The
// result register is the only buffer: characters are still taken while a result
// waits, but a further end item is held until the waiting result is transferred.
// The query is matched without regard to ASCII letter case; the user writes it through
// the csr_ port only while the unit is idle, which the block itself does not enforce.
module fuzzy_subsequence_window_match_unit #(
   parameter int MAX_QUERY     = fswm_pkg::DEFAULT_MAX_QUERY,
   parameter int POSITION_BITS = fswm_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [fswm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fswm_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [fswm_pkg::CHAR_BITS-1:0]       req_character,
   input  logic                                 req_is_end,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_score_kind,
   output logic [fswm_pkg::MATCH_BITS-1:0]      rsp_window_len,
   output logic [fswm_pkg::STR_LEN_BITS-1:0]    rsp_text_len,
   output logic                                 rsp_length_overflow
);
   import fswm_pkg::*;

   localparam int WIN_BITS = POSITION_BITS + 1;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   // Configuration registers.
   logic [QUERY_LEN_BITS-1:0] query_len_ff;
   logic [CSR_DATA_BITS-1:0]  chars_low_ff, chars_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         query_len_ff  <= '0;
         chars_low_ff  <= '0;
         chars_high_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_QUERY_LEN:  query_len_ff  <= csr_data[QUERY_LEN_BITS-1:0];
            CSR_CHARS_LOW:  chars_low_ff  <= csr_data;
            CSR_CHARS_HIGH: chars_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Lengths above the cell count act as the full chain.
   logic [QUERY_LEN_BITS-1:0] active_len;
   assign active_len = (query_len_ff > QUERY_LEN_BITS'(MAX_QUERY))
                       ? QUERY_LEN_BITS'(MAX_QUERY) : query_len_ff;

   // Input transfer; characters never need the result register.
   logic rsp_valid_ff, rsp_valid_in;
   logic accept, end_acc, char_acc, take;

   assign req_stall = rsp_valid_ff && rsp_stall && req_is_end;
   assign accept    = req_valid && !req_stall;
   assign end_acc   = accept && req_is_end;
   assign char_acc  = accept && !req_is_end;

   // Position counter and overflow flag.
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic                     ovf_ff, ovf_in;

   assign take = char_acc && (pos_ff != POS_MAX);

   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      if (end_acc) begin
         pos_in = '0;
         ovf_in = 1'b0;
      end else if (take) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end else if (char_acc) begin
         ovf_in = 1'b1;
      end
   end

   // Cell chain; cell zero sees an always-present empty prefix starting here.
   logic [CHAR_BITS-1:0]     char_folded;
   logic                     cell_valid [MAX_QUERY];
   logic [POSITION_BITS-1:0] cell_start [MAX_QUERY];
   logic                     cell_hit   [MAX_QUERY];
   logic [WIN_BITS-1:0]      cell_win   [MAX_QUERY];

   assign char_folded = fold_case(req_character);

   for (genvar k = 0; k < MAX_QUERY; k++) begin : g_cell
      cell_ctrl_type            ctrl;
      logic [CHAR_BITS-1:0]     qchar;
      logic                     pv;
      logic [POSITION_BITS-1:0] ps;

      if (k < CHARS_PER_WORD) begin : g_low
         assign qchar = chars_low_ff[k*CHAR_BITS +: CHAR_BITS];
      end else begin : g_high
         assign qchar = chars_high_ff[(k-CHARS_PER_WORD)*CHAR_BITS +: CHAR_BITS];
      end

      if (k == 0) begin : g_head
         assign pv = 1'b1;
         assign ps = pos_ff;
      end else begin : g_link
         assign pv = cell_valid[k-1];
         assign ps = cell_start[k-1];
      end

      assign ctrl = {take, end_acc, (QUERY_LEN_BITS'(k) < active_len),
                     ((QUERY_LEN_BITS'(k) + QUERY_LEN_BITS'(1)) == active_len)};

      fswm_cell #(
         .POSITION_BITS(POSITION_BITS)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .char_folded (char_folded),
         .target_char (qchar),
         .position    (pos_ff),
         .prev_valid  (pv),
         .prev_start  (ps),
         .valid       (cell_valid[k]),
         .start       (cell_start[k]),
         .win_hit     (cell_hit[k]),
         .win         (cell_win[k])
      );
   end

   // At most one cell completes a match per character, so the candidates are ORed.
   logic                cand_hit;
   logic [WIN_BITS-1:0] cand_win;

   always_comb begin
      cand_hit = 1'b0;
      cand_win = '0;
      for (int k = 0; k < MAX_QUERY; k++) begin
         cand_hit = cand_hit | cell_hit[k];
         cand_win = cand_win | (cell_hit[k] ? cell_win[k] : '0);
      end
   end

   // Shortest window seen so far; zero means none.
   logic [WIN_BITS-1:0] best_ff, best_in;

   always_comb begin
      best_in = best_ff;
      if (end_acc) begin
         best_in = '0;
      end else if (cand_hit && ((best_ff == '0) || (cand_win < best_ff))) begin
         best_in = cand_win;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         ovf_ff  <= 1'b0;
         best_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         ovf_ff  <= ovf_in;
         best_ff <= best_in;
      end
   end

   // Result formation from the state before the end item clears it.
   score_kind_type           kind;
   logic [WIDE_BITS-1:0]     best_wide, pos_wide;
   logic [MATCH_BITS-1:0]    match_val;
   logic [STR_LEN_BITS-1:0]  slen_val;

   assign best_wide = WIDE_BITS'(best_ff);
   assign pos_wide  = WIDE_BITS'(pos_ff);

   always_comb begin
      priority if (pos_ff == '0) begin
         kind = SCORE_ZERO;
      end else if (active_len == '0) begin
         kind = SCORE_FULL;
      end else if (best_ff == '0) begin
         kind = SCORE_ZERO;
      end else begin
         kind = SCORE_RATIO;
      end
      if (kind != SCORE_RATIO) begin
         match_val = '0;
      end else if (best_wide > MATCH_MAX) begin
         match_val = '1;
      end else begin
         match_val = best_wide[MATCH_BITS-1:0];
      end
      slen_val = (pos_wide > STR_LEN_MAX) ? '1 : pos_wide[STR_LEN_BITS-1:0];
   end

   // Result register.
   logic [1:0]              kind_ff;
   logic [MATCH_BITS-1:0]   match_ff;
   logic [STR_LEN_BITS-1:0] slen_ff;
   logic                    rovf_ff;

   assign rsp_valid_in = end_acc ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (end_acc) begin
         kind_ff  <= kind;
         match_ff <= match_val;
         slen_ff  <= slen_val;
         rovf_ff  <= ovf_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_score_kind      = kind_ff;
   assign rsp_window_len      = match_ff;
   assign rsp_text_len        = slen_ff;
   assign rsp_length_overflow = rovf_ff;

endmodule

>>> hdl/fswm_cell.sv
// One prefix cell of the match chain: holds the latest start of one query prefix.
// Depends on fswm_pkg; reads the state of its lower neighbour every cycle.
module fswm_cell #(
   parameter int POSITION_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fswm_pkg::cell_ctrl_type         ctrl,
   input  logic [fswm_pkg::CHAR_BITS-1:0]  char_folded,
   input  logic [fswm_pkg::CHAR_BITS-1:0]  target_char,
   input  logic [POSITION_BITS-1:0]        position,
   input  logic                            prev_valid,
   input  logic [POSITION_BITS-1:0]        prev_start,
   output logic                            valid,
   output logic [POSITION_BITS-1:0]        start,
   output logic                            win_hit,
   output logic [POSITION_BITS:0]          win
);
   import fswm_pkg::*;

   logic                     valid_ff, valid_in;
   logic [POSITION_BITS-1:0] start_ff, start_in;
   logic                     hit;

   // The prefix extends when this character matches and the shorter prefix exists.
   assign hit = ctrl.take && ctrl.in_use && prev_valid
                && (char_folded == fold_case(target_char));

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (hit) begin
         valid_in = 1'b1;
         start_in = prev_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      start_ff <= start_in;
   end

   // Window value for a completed match: window length plus one.
   assign win_hit = hit && ctrl.last;
   assign win     = {1'b0, position} - {1'b0, prev_start} + (POSITION_BITS+1)'(2);
   assign valid   = valid_ff;
   assign start   = start_ff;

endmodule
